// ===== design/ctcgd_pkg.sv =====
// Package: constants, types and codes shared by the greedy CTC decoder modules.
`default_nettype none
package ctcgd_pkg;

  localparam int unsigned MAX_CLASSES = 8192;
  localparam int unsigned MAX_STEPS   = 256;

  localparam int unsigned SCORE_W = 16;
  localparam int unsigned LABEL_W = 13;
  localparam int unsigned SUM_W   = 24;
  localparam int unsigned CNT_W   = 9;

  localparam int unsigned CLS_W   = $clog2(MAX_CLASSES);
  localparam int unsigned CCNT_W  = $clog2(MAX_CLASSES + 1);
  localparam int unsigned CNT_HW_MAX = (1 << CNT_W) - 1;
  localparam int unsigned CAP     = (MAX_STEPS < CNT_HW_MAX) ? MAX_STEPS : CNT_HW_MAX;
  localparam int unsigned DIV_CW  = $clog2(SUM_W);

  localparam logic [SUM_W-1:0]  SUM_MAX  = {SUM_W{1'b1}};
  localparam logic [CNT_W-1:0]  CAP_C    = CNT_W'(CAP);
  localparam logic [CCNT_W-1:0] MAXCLS_C = CCNT_W'(MAX_CLASSES);
  localparam logic [DIV_CW-1:0] DIV_LAST = DIV_CW'(SUM_W - 1);

  localparam logic KIND_CHAR  = 1'b0;
  localparam logic KIND_SCORE = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHAR,
    ST_DIV,
    ST_SCORE
  } state_e;

  typedef struct packed {
    logic take;
    logic div_start;
    logic div_run;
    logic seq_clear;
  } cmd_t;

  typedef struct packed {
    logic emit_char;
    logic seq_end;
    logic div_done;
  } sts_t;

endpackage
`default_nettype wire

// ===== design/ctcgd_ctrl.sv =====
// Controller: request sequencing, divider start and result hand-off.
`default_nettype none
module ctcgd_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  input  wire logic           out_stall_i,
  input  wire ctcgd_pkg::sts_t sts_i,
  output ctcgd_pkg::cmd_t     cmd_o,
  output logic                in_stall_o,
  output logic                out_valid_o
);

  ctcgd_pkg::state_e state_q, state_d;
  logic pend_q, pend_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ctcgd_pkg::ST_IDLE;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      pend_q  <= pend_d;
    end
  end

  always_comb begin
    state_d = state_q;
    pend_d  = pend_q;
    unique case (state_q)
      ctcgd_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          if (sts_i.emit_char) begin
            state_d = ctcgd_pkg::ST_CHAR;
            pend_d  = sts_i.seq_end;
          end else if (sts_i.seq_end) begin
            state_d = ctcgd_pkg::ST_DIV;
          end
        end
      end
      ctcgd_pkg::ST_CHAR: begin
        if (!out_stall_i) begin
          state_d = pend_q ? ctcgd_pkg::ST_DIV : ctcgd_pkg::ST_IDLE;
          pend_d  = 1'b0;
        end
      end
      ctcgd_pkg::ST_DIV: begin
        if (sts_i.div_done) state_d = ctcgd_pkg::ST_SCORE;
      end
      ctcgd_pkg::ST_SCORE: begin
        if (!out_stall_i) state_d = ctcgd_pkg::ST_IDLE;
      end
      default: state_d = ctcgd_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    unique case (state_q)
      ctcgd_pkg::ST_IDLE: begin
        in_stall_o      = 1'b0;
        cmd_o.take      = in_valid_i;
        cmd_o.div_start = in_valid_i & ~sts_i.emit_char & sts_i.seq_end;
      end
      ctcgd_pkg::ST_CHAR: begin
        out_valid_o     = 1'b1;
        cmd_o.div_start = ~out_stall_i & pend_q;
      end
      ctcgd_pkg::ST_DIV: begin
        cmd_o.div_run = 1'b1;
      end
      ctcgd_pkg::ST_SCORE: begin
        out_valid_o     = 1'b1;
        cmd_o.seq_clear = ~out_stall_i;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== design/ctcgd_dp.sv =====
// Datapath: per-step maximum, character accumulators, serial divider, result register.
`default_nettype none
module ctcgd_dp (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire ctcgd_pkg::cmd_t                cmd_i,
  output ctcgd_pkg::sts_t                     sts_o,
  input  wire logic [ctcgd_pkg::SCORE_W-1:0]  score_i,
  input  wire logic                           class_end_i,
  input  wire logic                           sequence_end_i,
  output logic                                kind_o,
  output logic [ctcgd_pkg::LABEL_W-1:0]       label_o,
  output logic [ctcgd_pkg::SCORE_W-1:0]       mean_score_o,
  output logic                                score_valid_o,
  output logic                                last_o
);

  localparam int unsigned SW  = ctcgd_pkg::SCORE_W;
  localparam int unsigned CW  = ctcgd_pkg::CLS_W;
  localparam int unsigned CCW = ctcgd_pkg::CCNT_W;
  localparam int unsigned UW  = ctcgd_pkg::SUM_W;
  localparam int unsigned NW  = ctcgd_pkg::CNT_W;
  localparam int unsigned DW  = ctcgd_pkg::DIV_CW;

  logic [SW-1:0]  best_score_q, best_score_d;
  logic [CW-1:0]  best_class_q, best_class_d;
  logic [CCW-1:0] class_cnt_q, class_cnt_d;
  logic [CW-1:0]  prev_class_q, prev_class_d;
  logic [UW-1:0]  sum_q, sum_d;
  logic [NW-1:0]  count_q, count_d;
  logic [NW-1:0]  rem_q, rem_d;
  logic [UW-1:0]  quo_q, quo_d;
  logic [DW-1:0]  div_cnt_q, div_cnt_d;

  logic [SW-1:0]  nb_score;
  logic [CW-1:0]  nb_class;
  logic           in_range;
  logic           step_end;
  logic           emit;
  logic [UW:0]    sum_add;
  logic [NW:0]    rem_sh;
  logic           ge;
  logic [UW-1:0]  quo_nx;
  logic           div_fin;

  always_comb begin
    in_range = class_cnt_q < ctcgd_pkg::MAXCLS_C;
    nb_score = best_score_q;
    nb_class = best_class_q;
    if (class_cnt_q == '0) begin
      nb_score = score_i;
      nb_class = '0;
    end else if (in_range && score_i > best_score_q) begin
      nb_score = score_i;
      nb_class = class_cnt_q[CW-1:0];
    end
    step_end = class_end_i | sequence_end_i;
    emit     = step_end && (nb_class != '0) && (nb_class != prev_class_q);
    sum_add  = {1'b0, sum_q} + (UW + 1)'(nb_score);
  end

  // restoring division, one quotient bit per cycle
  always_comb begin
    rem_sh  = {rem_q, quo_q[UW-1]};
    ge      = rem_sh >= {1'b0, count_q};
    rem_d   = ge ? NW'(rem_sh - {1'b0, count_q}) : rem_sh[NW-1:0];
    quo_nx  = {quo_q[UW-2:0], ge};
    div_fin = cmd_i.div_run && (div_cnt_q == ctcgd_pkg::DIV_LAST);
  end

  always_comb begin
    best_score_d = best_score_q;
    best_class_d = best_class_q;
    class_cnt_d  = class_cnt_q;
    prev_class_d = prev_class_q;
    sum_d        = sum_q;
    count_d      = count_q;
    quo_d        = quo_q;
    div_cnt_d    = div_cnt_q;
    if (cmd_i.take) begin
      if (step_end) begin
        best_score_d = '0;
        best_class_d = '0;
        class_cnt_d  = '0;
        prev_class_d = sequence_end_i ? '0 : nb_class;
        if (emit && count_q < ctcgd_pkg::CAP_C) begin
          sum_d   = sum_add[UW] ? ctcgd_pkg::SUM_MAX : sum_add[UW-1:0];
          count_d = count_q + NW'(1);
        end
      end else begin
        best_score_d = nb_score;
        best_class_d = nb_class;
        class_cnt_d  = in_range ? class_cnt_q + CCW'(1) : class_cnt_q;
      end
    end
    if (cmd_i.div_start) begin
      quo_d     = sum_q;
      div_cnt_d = '0;
    end else if (cmd_i.div_run) begin
      quo_d     = quo_nx;
      div_cnt_d = div_cnt_q + DW'(1);
    end
    if (cmd_i.seq_clear) begin
      sum_d   = '0;
      count_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_score_q <= '0;
      best_class_q <= '0;
      class_cnt_q  <= '0;
      prev_class_q <= '0;
      sum_q        <= '0;
      count_q      <= '0;
      div_cnt_q    <= '0;
    end else begin
      best_score_q <= best_score_d;
      best_class_q <= best_class_d;
      class_cnt_q  <= class_cnt_d;
      prev_class_q <= prev_class_d;
      sum_q        <= sum_d;
      count_q      <= count_d;
      div_cnt_q    <= div_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      rem_q <= '0;
    end else if (cmd_i.div_run) begin
      rem_q <= rem_d;
    end
    quo_q <= quo_d;
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.take && emit) begin
      kind_o        <= ctcgd_pkg::KIND_CHAR;
      label_o       <= ctcgd_pkg::LABEL_W'(nb_class);
      mean_score_o  <= '0;
      score_valid_o <= 1'b0;
      last_o        <= 1'b0;
    end else if (div_fin) begin
      kind_o        <= ctcgd_pkg::KIND_SCORE;
      label_o       <= '0;
      score_valid_o <= count_q != '0;
      last_o        <= 1'b1;
      if (count_q == '0) begin
        mean_score_o <= '0;
      end else if (quo_nx[UW-1:SW] != '0) begin
        mean_score_o <= {SW{1'b1}};
      end else begin
        mean_score_o <= quo_nx[SW-1:0];
      end
    end
  end

  assign sts_o = '{emit_char: emit, seq_end: sequence_end_i, div_done: div_fin};

endmodule
`default_nettype wire

// ===== design/ctc_greedy_decode_score.sv =====
// Top level of the greedy CTC decoder with mean confidence score.
//
//   channel  direction  handshake              payload
//   in       sink       in_valid_i/in_stall_o  score_i, class_end_i, sequence_end_i
//   out      source     out_valid_o/out_stall_i kind_o, label_o, mean_score_o,
//                                              score_valid_o, last_o
//
// A class request that yields no character leaves the input free for the next one; one that
// yields a character holds the input until that result is taken. A sequence end runs
// the bit-serial divider, after any character it yields is taken, then holds the
// score result until taken. Reset is asynchronous and needs no clearing pass.
// The input stalls whenever a result is pending or the divider is busy.
`default_nettype none
module ctc_greedy_decode_score (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic [ctcgd_pkg::SCORE_W-1:0]  score_i,
  input  wire logic                           class_end_i,
  input  wire logic                           sequence_end_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic                                kind_o,
  output logic [ctcgd_pkg::LABEL_W-1:0]       label_o,
  output logic [ctcgd_pkg::SCORE_W-1:0]       mean_score_o,
  output logic                                score_valid_o,
  output logic                                last_o
);

  ctcgd_pkg::cmd_t cmd;
  ctcgd_pkg::sts_t sts;

  ctcgd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o)
  );

  ctcgd_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .score_i        (score_i),
    .class_end_i    (class_end_i),
    .sequence_end_i (sequence_end_i),
    .kind_o         (kind_o),
    .label_o        (label_o),
    .mean_score_o   (mean_score_o),
    .score_valid_o  (score_valid_o),
    .last_o         (last_o)
  );

endmodule
`default_nettype wire

// ===== design/ctcgd_checker.sv =====
// Port-level checker for the greedy CTC decoder, bound to the top level.
`default_nettype none
module ctcgd_checker (
  input wire logic                           clk_i,
  input wire logic                           rst_ni,
  input wire logic                           in_stall_o,
  input wire logic                           out_valid_o,
  input wire logic                           out_stall_i,
  input wire logic                           kind_o,
  input wire logic [ctcgd_pkg::LABEL_W-1:0]  label_o,
  input wire logic [ctcgd_pkg::SCORE_W-1:0]  mean_score_o,
  input wire logic                           score_valid_o,
  input wire logic                           last_o
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(kind_o) && $stable(label_o)
      && $stable(mean_score_o) && $stable(score_valid_o) && $stable(last_o))
    else $error("result changed while stalled");

  a_no_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("request taken while a result is pending");

  a_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == ctcgd_pkg::KIND_CHAR |->
      !last_o && !score_valid_o && mean_score_o == '0 && label_o != '0)
    else $error("malformed character result");

  a_score: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == ctcgd_pkg::KIND_SCORE |->
      last_o && label_o == '0 && (score_valid_o || mean_score_o == '0))
    else $error("malformed score result");

endmodule

bind ctc_greedy_decode_score ctcgd_checker u_ctcgd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .kind_o        (kind_o),
  .label_o       (label_o),
  .mean_score_o  (mean_score_o),
  .score_valid_o (score_valid_o),
  .last_o        (last_o)
);
`default_nettype wire

// ===== sim/tb_ctc_greedy_decode_score.sv =====
// Testbench for the greedy CTC decoder: random-paced class requests checked against a predictor.
`timescale 1ns / 1ps
module tb_ctc_greedy_decode_score;

  localparam int unsigned RAND_ITEMS = 300;
  localparam int unsigned CAP_STEPS  = 258;
  localparam int unsigned MAX_WAIT   = 18;
  localparam int unsigned DRAIN_CYC  = 40;

  typedef struct packed {
    logic [ctcgd_pkg::SCORE_W-1:0] score;
    logic                          class_end;
    logic                          sequence_end;
  } class_req_t;

  typedef struct packed {
    logic                          kind;
    logic [ctcgd_pkg::LABEL_W-1:0] label;
    logic [ctcgd_pkg::SCORE_W-1:0] mean_score;
    logic                          score_valid;
    logic                          last;
  } decode_res_t;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          in_valid_i = 1'b0;
  logic                          in_stall_o;
  logic [ctcgd_pkg::SCORE_W-1:0] score_i = '0;
  logic                          class_end_i = 1'b0;
  logic                          sequence_end_i = 1'b0;
  logic                          out_valid_o;
  logic                          out_stall_i = 1'b0;
  logic                          kind_o;
  logic [ctcgd_pkg::LABEL_W-1:0] label_o;
  logic [ctcgd_pkg::SCORE_W-1:0] mean_score_o;
  logic                          score_valid_o;
  logic                          last_o;

  ctc_greedy_decode_score uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .score_i        (score_i),
    .class_end_i    (class_end_i),
    .sequence_end_i (sequence_end_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .kind_o         (kind_o),
    .label_o        (label_o),
    .mean_score_o   (mean_score_o),
    .score_valid_o  (score_valid_o),
    .last_o         (last_o)
  );

  always #1 clk_i = ~clk_i;

  class_req_t  req_q[$];
  decode_res_t decoded_q[$];

  // predictor state
  logic [ctcgd_pkg::SCORE_W-1:0] best_sc;
  logic [ctcgd_pkg::LABEL_W-1:0] best_cls;
  logic [ctcgd_pkg::LABEL_W-1:0] prev_cls;
  int unsigned                   cls_idx;
  int unsigned                   score_sum;
  int unsigned                   char_cnt;

  int unsigned n_errors = 0;
  int unsigned n_reqs = 0;
  int unsigned n_chars = 0;
  int unsigned n_scores = 0;

  logic        in_took = 1'b0;
  logic        out_took = 1'b0;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  int unsigned in_calm = 0;
  int unsigned out_calm = 0;
  int unsigned hold;
  class_req_t  drv_req;

  function automatic int unsigned idle_draw(inout int unsigned calm);
    if (calm != 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 24) == 0) calm = $urandom_range(8, 64);
    return $urandom_range(0, MAX_WAIT);
  endfunction

  function automatic void add_expected(input decode_res_t r);
    decoded_q = {decoded_q, r};
  endfunction

  function automatic void clear_decode();
    best_sc   = '0;
    best_cls  = '0;
    prev_cls  = '0;
    cls_idx   = 0;
    score_sum = 0;
    char_cnt  = 0;
  endfunction

  function automatic void decode_class(input logic [ctcgd_pkg::SCORE_W-1:0] sc,
                                       input logic ce, input logic se);
    int unsigned mean;
    logic        ok;
    if (cls_idx == 0) begin
      best_sc  = sc;
      best_cls = '0;
    end else if (cls_idx < ctcgd_pkg::MAX_CLASSES && sc > best_sc) begin
      best_sc  = sc;
      best_cls = ctcgd_pkg::LABEL_W'(cls_idx);
    end
    if (cls_idx < ctcgd_pkg::MAX_CLASSES) cls_idx++;
    if (ce || se) begin
      if (best_cls != 0 && best_cls != prev_cls) begin
        add_expected('{ctcgd_pkg::KIND_CHAR, best_cls, '0, 1'b0, 1'b0});
        if (char_cnt < ctcgd_pkg::CAP) begin
          score_sum = score_sum + best_sc;
          if (score_sum > 32'hFF_FFFF) score_sum = 32'hFF_FFFF;
          char_cnt++;
        end
      end
      prev_cls = best_cls;
      cls_idx  = 0;
      best_sc  = '0;
      best_cls = '0;
    end
    if (se) begin
      mean = 0;
      ok   = 1'b0;
      if (char_cnt != 0) begin
        mean = score_sum / char_cnt;
        if (mean > 32'hFFFF) mean = 32'hFFFF;
        ok = 1'b1;
      end
      add_expected('{ctcgd_pkg::KIND_SCORE, '0, ctcgd_pkg::SCORE_W'(mean), ok, 1'b1});
      clear_decode();
    end
  endfunction

  function automatic void check_result();
    decode_res_t exp_r;
    if (decoded_q.size() == 0) begin
      $error("unexpected result: kind %0d label %0d mean %0d", kind_o, label_o, mean_score_o);
      n_errors++;
      return;
    end
    exp_r = decoded_q.pop_front();
    if (exp_r.kind == ctcgd_pkg::KIND_CHAR) n_chars++;
    else n_scores++;
    if (kind_o !== exp_r.kind) begin
      $error("kind: expected %0d, got %0d", exp_r.kind, kind_o);
      n_errors++;
    end
    if (label_o !== exp_r.label) begin
      $error("label: expected %0d, got %0d", exp_r.label, label_o);
      n_errors++;
    end
    if (mean_score_o !== exp_r.mean_score) begin
      $error("mean_score: expected %0d, got %0d", exp_r.mean_score, mean_score_o);
      n_errors++;
    end
    if (score_valid_o !== exp_r.score_valid) begin
      $error("score_valid: expected %0d, got %0d", exp_r.score_valid, score_valid_o);
      n_errors++;
    end
    if (last_o !== exp_r.last) begin
      $error("last: expected %0d, got %0d", exp_r.last, last_o);
      n_errors++;
    end
  endfunction

  function automatic void push_req(input logic [ctcgd_pkg::SCORE_W-1:0] sc, input logic ce,
                                   input logic se);
    class_req_t r;
    r     = '{sc, ce, se};
    req_q = {req_q, r};
  endfunction

  // accept, predict and check at the rising edge
  always @(posedge clk_i) begin
    in_took  <= rst_ni && in_valid_i && !in_stall_o;
    out_took <= rst_ni && out_valid_o && !out_stall_i;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      decode_class(score_i, class_end_i, sequence_end_i);
      n_reqs++;
    end
    if (rst_ni && out_valid_o && !out_stall_i) check_result();
  end

  // request driver
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_took) begin
      if (gap_left != 0) begin
        in_valid_i <= 1'b0;
        gap_left   <= gap_left - 1;
      end else if (req_q.size() != 0) begin
        drv_req = req_q.pop_front();
        score_i        <= drv_req.score;
        class_end_i    <= drv_req.class_end;
        sequence_end_i <= drv_req.sequence_end;
        in_valid_i     <= 1'b1;
        gap_left       <= idle_draw(in_calm);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // result stall
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (out_took) begin
      hold = idle_draw(out_calm);
      out_stall_i <= (hold != 0);
      stall_left  <= (hold != 0) ? hold - 1 : 0;
    end else if (stall_left != 0) begin
      out_stall_i <= 1'b1;
      stall_left  <= stall_left - 1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  initial begin
    #10_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    int unsigned                   n_steps;
    int unsigned                   n_cls;
    int unsigned                   tgt;
    int unsigned                   rand_cnt;
    logic                          ties;
    logic                          last_cls;
    logic                          last_step;
    logic [ctcgd_pkg::SCORE_W-1:0] sc;

    clear_decode();

    // empty sequence: a single blank step
    push_req(16'd0, 1'b1, 1'b1);
    // character, repeat suppressed, blank on tie, earliest class wins tie
    push_req(16'd100, 1'b0, 1'b0);
    push_req(16'hFFFF, 1'b1, 1'b0);
    push_req(16'd0, 1'b0, 1'b0);
    push_req(16'hFFFF, 1'b1, 1'b0);
    push_req(16'hFFFF, 1'b0, 1'b0);
    push_req(16'hFFFF, 1'b0, 1'b0);
    push_req(16'd10, 1'b1, 1'b0);
    push_req(16'd5, 1'b0, 1'b0);
    push_req(16'd9, 1'b0, 1'b0);
    push_req(16'd9, 1'b1, 1'b0);
    // sequence end closes the step on its own
    push_req(16'd1, 1'b0, 1'b0);
    push_req(16'd2, 1'b0, 1'b0);
    push_req(16'd3, 1'b0, 1'b1);
    // both ends on one request
    push_req(16'd0, 1'b0, 1'b0);
    push_req(16'hFFFF, 1'b0, 1'b0);
    push_req(16'd0, 1'b1, 1'b1);
    // blank-only sequence of single-class steps
    push_req(16'hFFFF, 1'b1, 1'b0);
    push_req(16'd0, 1'b1, 1'b1);

    // more characters than the count can hold
    for (int s = 0; s < CAP_STEPS; s++) begin
      tgt = 1 + (s % 2);
      for (int c = 0; c < 3; c++) begin
        sc = (c == tgt) ? ctcgd_pkg::SCORE_W'($urandom_range(16'h8000, 16'hFFFF))
                        : ctcgd_pkg::SCORE_W'($urandom_range(0, 16'h7FFF));
        push_req(sc, c == 2, (c == 2) && (s == CAP_STEPS - 1));
      end
    end

    rand_cnt = 0;
    while (rand_cnt < RAND_ITEMS) begin
      if ($urandom_range(0, 9) == 0) begin
        // loose requests with stray ends
        n_cls = $urandom_range(1, 20);
        for (int i = 0; i < n_cls; i++) begin
          push_req(ctcgd_pkg::SCORE_W'($urandom), $urandom_range(0, 2) == 0,
                   (i == n_cls - 1) || ($urandom_range(0, 15) == 0));
          rand_cnt++;
        end
      end else begin
        n_steps = $urandom_range(1, 8);
        for (int s = 0; s < n_steps; s++) begin
          n_cls = ($urandom_range(0, 15) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6);
          ties  = ($urandom_range(0, 2) == 0);
          last_step = (s == n_steps - 1);
          for (int c = 0; c < n_cls; c++) begin
            if (ties) begin
              case ($urandom_range(0, 3))
                0: sc = 16'd0;
                1: sc = 16'd1;
                2: sc = 16'hFFFF;
                default: sc = 16'h8000;
              endcase
            end else begin
              sc = ctcgd_pkg::SCORE_W'($urandom);
            end
            last_cls = (c == n_cls - 1);
            push_req(sc, last_cls && (!last_step || $urandom_range(0, 2) != 0),
                     last_cls && last_step);
            rand_cnt++;
          end
        end
      end
    end

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (req_q.size() != 0 || in_valid_i) @(posedge clk_i);
    while (decoded_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYC) @(posedge clk_i);

    $display("%0d class requests driven; %0d characters and %0d sequence scores checked",
             n_reqs, n_chars, n_scores);
    $display("covered ties, blanks, repeats, stray ends and the character count cap");
    if (n_errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
